### design/prs80_pkg.sv
`timescale 1ns / 1ps

package prs80_pkg;

    localparam int BLOCK_W  = 64;
    localparam int KEY_HI_W = 64;
    localparam int KEY_LO_W = 16;
    localparam int KEY_W    = KEY_HI_W + KEY_LO_W;
    localparam int ROUND_W  = 5;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_COUNT  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FINAL_KEY_ADD = 8'd3;

    localparam logic [ROUND_W-1:0] ROUND_COUNT_RESET = 5'd5;

    function automatic logic [3:0] sbox4(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0: y = 4'hC;
            4'h1: y = 4'h5;
            4'h2: y = 4'h6;
            4'h3: y = 4'hB;
            4'h4: y = 4'h9;
            4'h5: y = 4'h0;
            4'h6: y = 4'hA;
            4'h7: y = 4'hD;
            4'h8: y = 4'h3;
            4'h9: y = 4'hE;
            4'hA: y = 4'hF;
            4'hB: y = 4'h8;
            4'hC: y = 4'h4;
            4'hD: y = 4'h7;
            4'hE: y = 4'h1;
            4'hF: y = 4'h2;
            default: y = 4'h0;
        endcase
        return y;
    endfunction

    function automatic logic [BLOCK_W-1:0] sbox_layer(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] r;
        r = '0;
        for (int n = 0; n < BLOCK_W / 4; n++) begin
            r[4*n +: 4] = sbox4(s[4*n +: 4]);
        end
        return r;
    endfunction

    function automatic logic [BLOCK_W-1:0] perm_layer(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] r;
        r = '0;
        for (int i = 0; i < BLOCK_W - 1; i++) begin
            r[(i * 16) % (BLOCK_W - 1)] = s[i];
        end
        r[BLOCK_W-1] = s[BLOCK_W-1];
        return r;
    endfunction

endpackage

### design/present80_block_encrypt.sv
`timescale 1ns / 1ps

// Channel  Direction  Ports                               Contents
// s_       in         s_tvalid s_tready s_tdata[63:0]     plaintext
// m_       out        m_tvalid m_tready m_tdata[63:0]     ciphertext
// cfg_     in         cfg_valid cfg_ready cfg_index cfg_data  register writes
//
// Each item runs from accept to the next accept as a load step,
// then round_count rounds through a single shared round unit, then a finish step.
// The finish step waits while the output register still holds an untaken item.
// Reset is synchronous, active low; it restores the register defaults
// (key 0, five rounds, no final key addition) and empties the output register.
// Configuration writes are taken in any cycle.

module present80_block_encrypt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] plaintext
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] ciphertext
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [prs80_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [prs80_pkg::CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg, state_next;

    logic [prs80_pkg::KEY_HI_W-1:0] key_upper_reg;
    logic [prs80_pkg::KEY_LO_W-1:0] key_lower_reg;
    logic [prs80_pkg::ROUND_W-1:0]  round_count_reg;
    logic                           final_key_add_reg;

    logic [prs80_pkg::BLOCK_W-1:0]  block_reg, block_next;
    logic [prs80_pkg::KEY_W-1:0]    rkey_reg, rkey_next;
    logic [prs80_pkg::ROUND_W-1:0]  round_idx_reg, round_idx_next;
    logic [prs80_pkg::BLOCK_W-1:0]  out_data_reg, out_data_next;
    logic                           out_valid_reg, out_valid_next;

    logic [prs80_pkg::BLOCK_W-1:0]  round_out;
    logic [prs80_pkg::KEY_W-1:0]    key_rot;
    logic [prs80_pkg::KEY_W-1:0]    key_upd;
    logic [prs80_pkg::ROUND_W-1:0]  round_idx_inc;
    logic [prs80_pkg::BLOCK_W-1:0]  final_data;
    logic                           out_free;
    logic                           in_accept;
    logic                           last_done;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign last_done = (round_idx_reg == round_count_reg);

    // shared round unit
    assign round_out = prs80_pkg::perm_layer(prs80_pkg::sbox_layer(
                           block_reg ^ rkey_reg[prs80_pkg::KEY_W-1 -: prs80_pkg::KEY_HI_W]));

    assign round_idx_inc = round_idx_reg + 1'b1;

    always_comb begin
        key_rot = {rkey_reg[18:0], rkey_reg[prs80_pkg::KEY_W-1:19]};
        key_upd = key_rot;
        key_upd[prs80_pkg::KEY_W-1 -: 4] = prs80_pkg::sbox4(key_rot[prs80_pkg::KEY_W-1 -: 4]);
        key_upd[19:15] = key_rot[19:15] ^ round_idx_inc;
    end

    assign final_data = block_reg ^ (final_key_add_reg
                        ? rkey_reg[prs80_pkg::KEY_W-1 -: prs80_pkg::KEY_HI_W]
                        : {prs80_pkg::BLOCK_W{1'b0}});

    always_comb begin
        state_next     = state_reg;
        block_next     = block_reg;
        rkey_next      = rkey_reg;
        round_idx_next = round_idx_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    block_next     = s_tdata;
                    rkey_next      = {key_upper_reg, key_lower_reg};
                    round_idx_next = '0;
                    state_next     = ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_done) begin
                    if (out_free) begin
                        out_data_next  = final_data;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    block_next     = round_out;
                    rkey_next      = key_upd;
                    round_idx_next = round_idx_inc;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        block_reg     <= block_next;
        rkey_reg      <= rkey_next;
        round_idx_reg <= round_idx_next;
        out_data_reg  <= out_data_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_upper_reg     <= '0;
            key_lower_reg     <= '0;
            round_count_reg   <= prs80_pkg::ROUND_COUNT_RESET;
            final_key_add_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                prs80_pkg::REG_KEY_UPPER: begin
                    key_upper_reg <= cfg_data[prs80_pkg::KEY_HI_W-1:0];
                end
                prs80_pkg::REG_KEY_LOWER: begin
                    key_lower_reg <= cfg_data[prs80_pkg::KEY_LO_W-1:0];
                end
                prs80_pkg::REG_ROUND_COUNT: begin
                    round_count_reg <= cfg_data[prs80_pkg::ROUND_W-1:0];
                end
                prs80_pkg::REG_FINAL_KEY_ADD: begin
                    final_key_add_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### design/prs80_checker.sv
`timescale 1ns / 1ps

module prs80_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [prs80_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [prs80_pkg::CFG_DATA_W-1:0] cfg_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // busy after an accepted item
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // a finished item leaves a result behind
    a_done_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $rose(s_tready) |-> m_tvalid)
        else $error("item finished without a result");

    // reset empties the output
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind present80_block_encrypt prs80_checker u_prs80_checker (.*);
